// File: hdl/brm_pkg.sv
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types and constants for the bounded random multistream generator.
// ----------------------------------------------------------------------------
package brm_pkg;

    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;
    localparam int          MIX_SH0    = 30;
    localparam int          MIX_SH1    = 27;
    localparam int          MIX_SH2    = 31;
    localparam int          XO_ROT_OUT = 23;
    localparam int          XO_SHL     = 17;
    localparam int          XO_ROT_W3  = 45;
    localparam logic        CMD_RESEED = 1'b0;
    localparam logic        CMD_DRAW   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MIX_ADD,
        S_MIX_MUL,
        S_ROW_WR,
        S_RD,
        S_CHK,
        S_GEN,
        S_MUL,
        S_TEST,
        S_DIV,
        S_CMP,
        S_WB,
        S_DONE
    } brm_state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_MIN,
        RES_DRAW
    } brm_res_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_item;
        logic       mix_add;
        logic       mul_mix;
        logic [1:0] mul_phase;
        logic       mul_const;
        logic       push_word;
        logic       row_wr;
        logic       row_inc;
        logic       mem_rd;
        logic       w_load;
        logic       gen;
        logic       mul_draw;
        logic       div_init;
        logic       div_step;
        logic       wb;
        logic       out_load;
        brm_res_t   res_sel;
    } brm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_last;
        logic sid_bad;
        logic zero_state;
        logic span_zero;
        logic low_lt_span;
        logic low_lt_thresh;
    } brm_stat_t;

endpackage

// File: hdl/bounded_random_multistream.sv
// ----------------------------------------------------------------------------
// bounded_random_multistream
// Multistream xoshiro256++ generator with bounded 32-bit draws.
// ----------------------------------------------------------------------------
// Holds STREAMS xoshiro256++ states (four 64-bit words each) in a row memory
// with one valid bit per row, so unseeded streams read as zero. A reseed word
// (tuser = 0) fills every stream from the splitmix64 counter, loaded by a
// cfg write; each splitmix output is worked out on the one shared 32x32
// multiplier (two 64-bit products in three partial steps each), and a reseed
// answers 0. A draw word (tuser = 1) answers range_min + high(out[31:0] * span)
// by multiply-and-reject, or range_min for a bad stream id or unseeded stream;
// the rejection threshold is worked out the first time it is needed
// (bit-serial remainder, one bit a cycle) and kept for any redraws. One word
// is worked on at a time; a finished result waits in the output register
// while the next word is taken in.
// ----------------------------------------------------------------------------
module bounded_random_multistream
    import brm_pkg::*;
#(
    parameter int STREAMS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,     // seed
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata, // stream_id[2:0], range_min[34:3], range_max[66:35]
    input  logic [0:0]  s_axis_tuser, // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata  // value[31:0]
);

    brm_cmd_t  cmd;
    brm_stat_t stat;

    // the user must send seed writes only while idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    brm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser[0]),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    brm_dp #(
        .STREAMS (STREAMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .value     (m_axis_tdata)
    );

    // result load never overwrites a word still waiting downstream
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over pending word");

    // a reseed always answers zero
    a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.res_sel == RES_ZERO) |=> (m_axis_tdata == 32'd0))
        else $error("reseed result not zero");

    // memory is only touched while a word is being worked on
    a_mem_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.row_wr || cmd.wb) |-> !s_axis_tready)
        else $error("state memory written while idle");

    // one command word in, one result out
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> s_axis_tready)
        else $error("controller not idle after result");

endmodule

// File: hdl/brm_dp.sv
// ----------------------------------------------------------------------------
// brm_dp
// Datapath: stream state memory, splitmix64 seeder, xoshiro256++ step,
// shared 32x32 multiplier, serial remainder unit and result register.
// ----------------------------------------------------------------------------
module brm_dp
    import brm_pkg::*;
#(
    parameter int STREAMS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [63:0] cfg_data,
    input  logic [71:0] in_data,
    input  brm_cmd_t    cmd,
    output brm_stat_t   stat,
    output logic [31:0] value
);

    localparam int IW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    logic [2:0]   sid_reg;
    logic [31:0]  lo_reg;
    logic [31:0]  span_reg;
    logic [63:0]  mix_reg;
    logic [63:0]  z_reg;
    logic [63:0]  acc_reg;
    logic [255:0] row_buf_reg;
    logic [IW-1:0] row_reg;
    logic [255:0] rd_reg;
    logic         rd_valid_reg;
    logic [63:0]  w_reg [4];
    logic [31:0]  gen_lo_reg;
    logic [63:0]  prod_reg;
    logic [31:0]  rem_reg;
    logic [31:0]  dvd_reg;
    logic [31:0]  value_reg;
    logic [255:0] mem [STREAMS];
    logic [STREAMS-1:0] valid_reg;

    logic [IW-1:0] sid_addr;
    logic [63:0]   mix_sum;
    logic [63:0]   kc;
    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   mul_p;
    logic [63:0]   t_sum;
    logic [63:0]   fin1;
    logic [63:0]   fin2;
    logic [255:0]  rd_masked;
    logic [63:0]   sum03;
    logic [63:0]   gen_out;
    logic [63:0]   w2x, w3x, w1x, w0x, w2n, w3n;
    logic [32:0]   div_r;

    assign sid_addr = IW'(sid_reg);
    assign mix_sum  = mix_reg + MIX_GOLDEN;
    assign kc       = cmd.mul_const ? MIX_C2 : MIX_C1;

    always_comb
    begin
        if (cmd.mul_draw)
        begin
            mul_a = gen_lo_reg;
            mul_b = span_reg;
        end
        else
        begin
            mul_a = (cmd.mul_phase == 2'd2) ? z_reg[63:32] : z_reg[31:0];
            mul_b = (cmd.mul_phase == 2'd1) ? kc[63:32] : kc[31:0];
        end
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    assign t_sum = acc_reg + {mul_p[31:0], 32'd0};
    assign fin1  = t_sum ^ (t_sum >> MIX_SH1);
    assign fin2  = t_sum ^ (t_sum >> MIX_SH2);

    // xoshiro256++ step
    assign rd_masked = rd_valid_reg ? rd_reg : 256'd0;
    assign sum03   = w_reg[0] + w_reg[3];
    assign gen_out = ((sum03 << XO_ROT_OUT) | (sum03 >> (64 - XO_ROT_OUT))) + w_reg[0];
    assign w2x = w_reg[2] ^ w_reg[0];
    assign w3x = w_reg[3] ^ w_reg[1];
    assign w1x = w_reg[1] ^ w2x;
    assign w0x = w_reg[0] ^ w3x;
    assign w2n = w2x ^ (w_reg[1] << XO_SHL);
    assign w3n = (w3x << XO_ROT_W3) | (w3x >> (64 - XO_ROT_W3));

    assign div_r = {rem_reg, dvd_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg   <= 64'd0;
            valid_reg <= '0;
            row_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
                mix_reg <= cfg_data;
            else if (cmd.mix_add)
                mix_reg <= mix_sum;
            if (cmd.load_item)
                row_reg <= '0;
            else if (cmd.row_inc)
                row_reg <= row_reg + 1'b1;
            if (cmd.row_wr)
                valid_reg[row_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_wr)
            mem[row_reg] <= row_buf_reg;
        else if (cmd.wb)
            mem[sid_addr] <= {w_reg[3], w_reg[2], w_reg[1], w_reg[0]};
        if (cmd.mem_rd)
        begin
            rd_reg       <= mem[sid_addr];
            rd_valid_reg <= valid_reg[sid_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            sid_reg  <= in_data[2:0];
            lo_reg   <= in_data[34:3];
            span_reg <= in_data[66:35] - in_data[34:3] + 32'd1;
        end
        if (cmd.mix_add)
            z_reg <= mix_sum ^ (mix_sum >> MIX_SH0);
        if (cmd.mul_mix)
        begin
            unique case (cmd.mul_phase)
                2'd0:    acc_reg <= mul_p;
                2'd1:    acc_reg <= t_sum;
                default: z_reg   <= fin1;
            endcase
        end
        if (cmd.push_word)
            row_buf_reg <= {fin2, row_buf_reg[255:64]};
        if (cmd.w_load)
        begin
            w_reg[0] <= rd_masked[63:0];
            w_reg[1] <= rd_masked[127:64];
            w_reg[2] <= rd_masked[191:128];
            w_reg[3] <= rd_masked[255:192];
        end
        else if (cmd.gen)
        begin
            w_reg[0]   <= w0x;
            w_reg[1]   <= w1x;
            w_reg[2]   <= w2n;
            w_reg[3]   <= w3n;
            gen_lo_reg <= gen_out[31:0];
        end
        if (cmd.mul_draw)
            prod_reg <= mul_p;
        if (cmd.div_init)
        begin
            rem_reg <= 32'd0;
            dvd_reg <= 32'd0 - span_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= (div_r >= {1'b0, span_reg}) ? 32'(div_r - {1'b0, span_reg})
                                                   : div_r[31:0];
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
        if (cmd.out_load)
        begin
            unique case (cmd.res_sel)
                RES_ZERO: value_reg <= 32'd0;
                RES_MIN:  value_reg <= lo_reg;
                default:  value_reg <= lo_reg + prod_reg[63:32];
            endcase
        end
    end

    assign value              = value_reg;
    assign stat.row_last      = (32'(row_reg) == STREAMS - 1);
    assign stat.sid_bad       = (32'(sid_reg) >= STREAMS);
    assign stat.zero_state    = (rd_masked == 256'd0);
    assign stat.span_zero     = (span_reg == 32'd0);
    assign stat.low_lt_span   = (prod_reg[31:0] < span_reg);
    assign stat.low_lt_thresh = (prod_reg[31:0] < rem_reg);

endmodule

// File: hdl/brm_ctrl.sv
// ----------------------------------------------------------------------------
// brm_ctrl
// Sequencer for reseed and draw commands, plus the output word slot.
// ----------------------------------------------------------------------------
module brm_ctrl
    import brm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_cmd,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  brm_stat_t stat,
    output brm_cmd_t  cmd
);

    brm_state_t state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       const_reg, const_next;
    logic [1:0] word_reg, word_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic       known_reg, known_next;
    brm_res_t   res_reg, res_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 2'd0;
            const_reg     <= 1'b0;
            word_reg      <= 2'd0;
            div_cnt_reg   <= 5'd0;
            known_reg     <= 1'b0;
            res_reg       <= RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            const_reg     <= const_next;
            word_reg      <= word_next;
            div_cnt_reg   <= div_cnt_next;
            known_reg     <= known_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        const_next     = const_reg;
        word_next      = word_reg;
        div_cnt_next   = div_cnt_reg;
        known_next     = known_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_sel    = res_reg;
        cmd.mul_phase  = phase_reg;
        cmd.mul_const  = const_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    phase_next    = 2'd0;
                    const_next    = 1'b0;
                    word_next     = 2'd0;
                    known_next    = 1'b0;
                    state_next    = (in_cmd == CMD_DRAW) ? S_RD : S_MIX_ADD;
                end
            end
            S_MIX_ADD:
            begin
                cmd.mix_add = 1'b1;
                phase_next  = 2'd0;
                const_next  = 1'b0;
                state_next  = S_MIX_MUL;
            end
            S_MIX_MUL:
            begin
                cmd.mul_mix = 1'b1;
                if (phase_reg != 2'd2)
                    phase_next = phase_reg + 2'd1;
                else if (!const_reg)
                begin
                    phase_next = 2'd0;
                    const_next = 1'b1;
                end
                else
                begin
                    cmd.push_word = 1'b1;
                    word_next     = word_reg + 2'd1;
                    state_next    = (word_reg == 2'd3) ? S_ROW_WR : S_MIX_ADD;
                end
            end
            S_ROW_WR:
            begin
                cmd.row_wr = 1'b1;
                if (stat.row_last)
                begin
                    res_next   = RES_ZERO;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_MIX_ADD;
                end
            end
            S_RD:
            begin
                cmd.mem_rd = 1'b1;
                if (stat.sid_bad)
                begin
                    res_next   = RES_MIN;
                    state_next = S_DONE;
                end
                else
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                cmd.w_load = 1'b1;
                if (stat.zero_state)
                begin
                    res_next   = RES_MIN;
                    state_next = S_DONE;
                end
                else
                    state_next = S_GEN;
            end
            S_GEN:
            begin
                cmd.gen    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_draw = 1'b1;
                state_next   = S_TEST;
            end
            S_TEST:
            begin
                if (!stat.span_zero && stat.low_lt_span)
                begin
                    if (!known_reg)
                    begin
                        cmd.div_init = 1'b1;
                        div_cnt_next = 5'd0;
                        state_next   = S_DIV;
                    end
                    else
                        state_next = stat.low_lt_thresh ? S_GEN : S_WB;
                end
                else
                    state_next = S_WB;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd31)
                begin
                    known_next = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = stat.low_lt_thresh ? S_GEN : S_WB;
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                res_next   = RES_DRAW;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
